// File: src/bresenham_line_stepper_macros.svh
// Assertion macros used by the line stepper RTL.
`ifndef BRESENHAM_LINE_STEPPER_MACROS_SVH
`define BRESENHAM_LINE_STEPPER_MACROS_SVH

// cond implies expr in the same cycle
`define BLS_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// cond implies expr in the next cycle
`define BLS_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: src/bls_pkg.sv
// Shared request codes and direction flags for the line stepper.
package bls_pkg;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_STEP  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic steep;
      logic minor_neg;
   } line_dir_type;

endpackage

// File: src/bls_setup.sv
// Line setup: classify, order endpoints, first pixel and initial error term.
module bls_setup #(
   parameter int COORD_BITS = 12
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic        [COORD_BITS-1:0] first_x,
   output logic        [COORD_BITS-1:0] first_y,
   output logic        [COORD_BITS:0]   major_delta,
   output logic        [COORD_BITS:0]   minor_delta,
   output logic        [COORD_BITS+2:0] err_init,
   output bls_pkg::line_dir_type        dir
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic        [COORD_BITS:0] adx;
   logic        [COORD_BITS:0] ady;
   logic                       steep;
   logic                       swap;
   logic                       minor_pos;
   logic                       minor_neg;

   assign dx  = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
   assign dy  = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
   assign adx = dx[COORD_BITS] ? -dx : dx;
   assign ady = dy[COORD_BITS] ? -dy : dy;

   assign steep = !(ady < adx);
   assign swap  = steep ? (start_y > end_y) : (start_x > end_x);

   always_comb begin
      if (steep) begin
         minor_pos = !dx[COORD_BITS] && (|dx);
         minor_neg = dx[COORD_BITS];
      end else begin
         minor_pos = !dy[COORD_BITS] && (|dy);
         minor_neg = dy[COORD_BITS];
      end
   end

   assign first_x       = swap ? end_x : start_x;
   assign first_y       = swap ? end_y : start_y;
   assign major_delta   = steep ? ady : adx;
   assign minor_delta   = steep ? adx : ady;
   assign dir.steep     = steep;
   assign dir.minor_neg = swap ? minor_pos : minor_neg;
   assign err_init      = {1'b0, minor_delta, 1'b0} - {2'b00, major_delta};

endmodule

// File: src/bls_step.sv
// Single Bresenham step: advance the major axis, maybe the minor, update error and count.
module bls_step #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0] pos_x,
   input  logic [COORD_BITS-1:0] pos_y,
   input  logic [COORD_BITS+2:0] err_term,
   input  logic [COORD_BITS:0]   major_delta,
   input  logic [COORD_BITS:0]   minor_delta,
   input  logic [COORD_BITS:0]   pixels_left,
   input  bls_pkg::line_dir_type dir,
   output logic [COORD_BITS-1:0] next_x,
   output logic [COORD_BITS-1:0] next_y,
   output logic [COORD_BITS+2:0] next_err,
   output logic [COORD_BITS:0]   next_left
);

   logic                  move_minor;
   logic [COORD_BITS+2:0] err_inc;
   logic [COORD_BITS-1:0] minor_inc;
   logic [COORD_BITS-1:0] minor_add;

   assign move_minor = !err_term[COORD_BITS+2] && (|err_term);
   assign err_inc    = move_minor ?
                       ({1'b0, minor_delta, 1'b0} - {1'b0, major_delta, 1'b0}) :
                       {1'b0, minor_delta, 1'b0};
   assign next_err   = err_term + err_inc;
   assign minor_inc  = dir.minor_neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
   assign minor_add  = move_minor ? minor_inc : '0;

   always_comb begin
      if (dir.steep) begin
         next_x = pos_x + minor_add;
         next_y = pos_y + COORD_BITS'(1);
      end else begin
         next_x = pos_x + COORD_BITS'(1);
         next_y = pos_y + minor_add;
      end
   end

   assign next_left = pixels_left - (COORD_BITS+1)'(1);

endmodule

// File: src/bresenham_line_stepper.sv
// Bresenham line stepper top level: input register, line state, result register.
// A transferred request waits in the input register until the result register can
// advance; its pixel is then registered. One request per cycle unless rsp_stall holds.
// Start emits the first pixel; each step emits one pixel; step while idle emits none.
// Reset (synchronous, active high) empties both registers and clears the line state.
`include "bresenham_line_stepper_macros.svh"

module bresenham_line_stepper #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last_pixel
);

   logic                         in_valid_ff;
   logic                         in_type_ff;
   logic signed [COORD_BITS-1:0] in_start_x_ff;
   logic signed [COORD_BITS-1:0] in_start_y_ff;
   logic signed [COORD_BITS-1:0] in_end_x_ff;
   logic signed [COORD_BITS-1:0] in_end_y_ff;

   logic [COORD_BITS-1:0] pos_x_ff,       pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff,       pos_y_in;
   logic [COORD_BITS+2:0] err_term_ff,    err_term_in;
   logic [COORD_BITS:0]   major_delta_ff, major_delta_in;
   logic [COORD_BITS:0]   minor_delta_ff, minor_delta_in;
   logic [COORD_BITS:0]   pixels_left_ff, pixels_left_in;
   bls_pkg::line_dir_type dir_ff,         dir_in;
   logic                  busy_ff,        busy_in;

   logic                         rsp_valid_ff,  rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff;
   logic signed [COORD_BITS-1:0] rsp_y_ff;
   logic                         rsp_last_ff;

   logic                  req_xfer;
   logic                  advance;
   logic                  fire;
   logic                  is_start;
   logic                  emit;

   logic [COORD_BITS-1:0] setup_x;
   logic [COORD_BITS-1:0] setup_y;
   logic [COORD_BITS:0]   setup_major;
   logic [COORD_BITS:0]   setup_minor;
   logic [COORD_BITS+2:0] setup_err;
   bls_pkg::line_dir_type setup_dir;

   logic [COORD_BITS-1:0] step_x;
   logic [COORD_BITS-1:0] step_y;
   logic [COORD_BITS+2:0] step_err;
   logic [COORD_BITS:0]   step_left;

   bls_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .start_x     (in_start_x_ff),
      .start_y     (in_start_y_ff),
      .end_x       (in_end_x_ff),
      .end_y       (in_end_y_ff),
      .first_x     (setup_x),
      .first_y     (setup_y),
      .major_delta (setup_major),
      .minor_delta (setup_minor),
      .err_init    (setup_err),
      .dir         (setup_dir)
   );

   bls_step #(.COORD_BITS(COORD_BITS)) u_step (
      .pos_x       (pos_x_ff),
      .pos_y       (pos_y_ff),
      .err_term    (err_term_ff),
      .major_delta (major_delta_ff),
      .minor_delta (minor_delta_ff),
      .pixels_left (pixels_left_ff),
      .dir         (dir_ff),
      .next_x      (step_x),
      .next_y      (step_y),
      .next_err    (step_err),
      .next_left   (step_left)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;
   assign fire      = in_valid_ff && advance;
   assign is_start  = (in_type_ff == bls_pkg::REQ_START);
   assign emit      = is_start || busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_type_ff    <= req_type;
         in_start_x_ff <= req_start_x;
         in_start_y_ff <= req_start_y;
         in_end_x_ff   <= req_end_x;
         in_end_y_ff   <= req_end_y;
      end
   end

   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      err_term_in    = err_term_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      pixels_left_in = pixels_left_ff;
      dir_in         = dir_ff;
      busy_in        = busy_ff;
      if (fire && is_start) begin
         pos_x_in       = setup_x;
         pos_y_in       = setup_y;
         err_term_in    = setup_err;
         major_delta_in = setup_major;
         minor_delta_in = setup_minor;
         pixels_left_in = setup_major;
         dir_in         = setup_dir;
         busy_in        = (setup_major != '0);
      end else if (fire && busy_ff) begin
         pos_x_in       = step_x;
         pos_y_in       = step_y;
         err_term_in    = step_err;
         pixels_left_in = step_left;
         busy_in        = (step_left != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         err_term_ff    <= '0;
         major_delta_ff <= '0;
         minor_delta_ff <= '0;
         pixels_left_ff <= '0;
         dir_ff         <= '0;
         busy_ff        <= 1'b0;
      end else begin
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         err_term_ff    <= err_term_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         pixels_left_ff <= pixels_left_in;
         dir_ff         <= dir_in;
         busy_ff        <= busy_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_x_ff    <= pos_x_in;
         rsp_y_ff    <= pos_y_in;
         rsp_last_ff <= (pixels_left_in == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_x    = rsp_x_ff;
   assign rsp_pixel_y    = rsp_y_ff;
   assign rsp_last_pixel = rsp_last_ff;

   `BLS_ASSERT_NOW(a_busy_matches_left, 1'b1, busy_ff == (pixels_left_ff != '0), "busy flag out of step with pixel count")
   `BLS_ASSERT_NOW(a_last_means_idle, rsp_valid_ff, rsp_last_ff == !busy_ff, "last pixel flag disagrees with line state")
   `BLS_ASSERT_NEXT(a_step_counts_down, fire && !is_start && busy_ff, pixels_left_ff == $past(pixels_left_ff) - (COORD_BITS+1)'(1), "step did not consume one pixel")

endmodule

// File: tb/sv/bresenham_line_stepper_tb.sv
// Self-checking testbench for the Bresenham line stepper: directed and random lines.
`timescale 1ns / 1ps

module bresenham_line_stepper_tb;

   localparam int CW         = 12;
   localparam int RAND_ITEMS = 740;
   localparam int HOLD_AT    = 300;
   localparam int LONG_HOLD  = 300;
   localparam int QUIET_MAX  = 3000;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      bls_pkg::req_kind_type kind;
      coord_type             sx;
      coord_type             sy;
      coord_type             ex;
      coord_type             ey;
      logic                  drain;
   } line_req_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_type = 1'b0;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   logic      rsp_last_pixel;

   line_req_type line_reqs[$];
   pixel_type    pixel_expect[$];
   line_req_type cur_req;
   pixel_type    want_px;
   pixel_type    next_px;
   bit           emitted;

   int line_x, line_y, line_err, line_major, line_minor, line_left;
   bit line_minor_neg, line_steep, line_busy;

   int issued = 0;
   int rsp_count = 0;
   int mismatches = 0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int quiet = 0;
   bit held_long = 1'b0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   bresenham_line_stepper #(.COORD_BITS(CW)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always #1 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic coord_type near_coord(coord_type c, int span);
      int v;
      v = $signed(c) + int'($urandom_range(0, 2 * span)) - span;
      if (v < -(1 << (CW - 1))) v = -(1 << (CW - 1));
      if (v > (1 << (CW - 1)) - 1) v = (1 << (CW - 1)) - 1;
      return coord_type'(v);
   endfunction

   function automatic int major_len(coord_type sx, coord_type sy, coord_type ex,
                                    coord_type ey);
      int adx, ady;
      adx = $signed(ex) - $signed(sx);
      ady = $signed(ey) - $signed(sy);
      if (adx < 0) adx = -adx;
      if (ady < 0) ady = -ady;
      return (adx > ady) ? adx : ady;
   endfunction

   // Advance the line state by one request and produce the pixel it emits, if any.
   task automatic trace_pixel(input line_req_type r, output bit got, output pixel_type px);
      int x0, y0, x1, y1, dx, dy, adx, ady, minor_diff, minor_inc;
      bit move_minor;
      got = 1'b0;
      px = '0;
      if (r.kind == bls_pkg::REQ_START) begin
         x0 = $signed(r.sx);
         y0 = $signed(r.sy);
         x1 = $signed(r.ex);
         y1 = $signed(r.ey);
         dx = x1 - x0;
         dy = y1 - y0;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         line_steep = !(ady < adx);
         if (!line_steep) begin
            if (x0 > x1) begin
               line_x = x1; line_y = y1; minor_diff = -dy;
            end else begin
               line_x = x0; line_y = y0; minor_diff = dy;
            end
            line_major = adx;
         end else begin
            if (y0 > y1) begin
               line_x = x1; line_y = y1; minor_diff = -dx;
            end else begin
               line_x = x0; line_y = y0; minor_diff = dx;
            end
            line_major = ady;
         end
         line_minor_neg = minor_diff < 0;
         line_minor = minor_diff < 0 ? -minor_diff : minor_diff;
         line_err = 2 * line_minor - line_major;
         line_left = line_major;
         line_busy = line_left != 0;
         got = 1'b1;
      end else if (line_busy) begin
         minor_inc = line_minor_neg ? -1 : 1;
         move_minor = line_err > 0;
         if (move_minor) line_err += 2 * (line_minor - line_major);
         else line_err += 2 * line_minor;
         if (line_steep) begin
            line_y += 1;
            if (move_minor) line_x += minor_inc;
         end else begin
            line_x += 1;
            if (move_minor) line_y += minor_inc;
         end
         line_left -= 1;
         line_busy = line_left != 0;
         got = 1'b1;
      end
      if (got) begin
         px.x = line_x[CW-1:0];
         px.y = line_y[CW-1:0];
         px.last = (line_left == 0);
      end
   endtask

   task automatic add_start(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                            bit drain);
      line_req_type r;
      r.kind = bls_pkg::REQ_START;
      r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
      r.drain = drain;
      line_reqs.push_back(r);
   endtask

   // Step fields are ignored by the block; fill them with noise.
   task automatic add_steps(int n);
      line_req_type r;
      for (int i = 0; i < n; i++) begin
         r.kind = bls_pkg::REQ_STEP;
         r.sx = coord_type'($urandom); r.sy = coord_type'($urandom);
         r.ex = coord_type'($urandom); r.ey = coord_type'($urandom);
         r.drain = 1'b0;
         line_reqs.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, pixel_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: got (%0d,%0d,last=%0b) expected (%0d,%0d,last=%0b)", $realtime,
                  what, rsp_pixel_x, rsp_pixel_y, rsp_last_pixel, want.x, want.y, want.last);
   endtask

   // Request driver: predict on each transfer, then offer the next item or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            trace_pixel(cur_req, emitted, next_px);
            if (emitted) begin
               pixel_expect.push_back(next_px);
               issued++;
            end
            send_gap = tx_steady ? 0 : idle_len();
            if ($urandom_range(0, 99) < 3) tx_steady = !tx_steady;
         end
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (line_reqs.size() > 0 && !(line_reqs[0].drain && issued != rsp_count)) begin
            cur_req = line_reqs.pop_front();
            req_type <= cur_req.kind;
            req_start_x <= cur_req.sx;
            req_start_y <= cur_req.sy;
            req_end_x <= cur_req.ex;
            req_end_y <= cur_req.ey;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Pixel monitor and receiver stall control.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (pixel_expect.size() == 0) begin
               report_mismatch("unexpected pixel", '0);
            end else begin
               want_px = pixel_expect.pop_front();
               if (rsp_pixel_x !== want_px.x || rsp_pixel_y !== want_px.y ||
                   rsp_last_pixel !== want_px.last)
                  report_mismatch("pixel mismatch", want_px);
            end
         end
         if ($urandom_range(0, 99) == 0) rx_steady <= !rx_steady;
         if (!held_long && rsp_count >= HOLD_AT) begin
            held_long <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (rx_steady) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = idle_len();
            rsp_stall <= stall_left > 0;
            if (stall_left > 0) stall_left = stall_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
         $display("[bresenham_line_stepper] ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int rand_items;
      int sel;
      int span;
      int major;
      int steps;
      coord_type x0, y0, x1, y1;

      // directed: idle step, zero length, extremes, drop while busy, both orderings
      add_steps(1);
      add_start(12'sd0, 12'sd0, 12'sd0, 12'sd0, 1'b0);
      add_steps(1);
      add_start(12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047, 1'b0);
      add_steps(2);
      add_start(12'sd4, -12'sd1, -12'sd5, 12'sd3, 1'b0);
      add_steps(10);
      add_start(12'sd0, 12'sd0, 12'sd1, 12'sd5, 1'b0);
      add_steps(2);
      add_start(-12'sd2048, 12'sd2047, -12'sd2048, 12'sd2047, 1'b0);

      // shallow line across the whole coordinate range, dropped part way along
      add_start(12'sd2047, 12'sd2047, -12'sd2048, -12'sd2047, 1'b1);
      add_steps(60);

      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 75) begin
            x0 = coord_type'($urandom);
            y0 = coord_type'($urandom);
            span = ($urandom_range(0, 29) == 0) ? 200 : 12;
            x1 = near_coord(x0, span);
            y1 = near_coord(y0, span);
            major = major_len(x0, y0, x1, y1);
            steps = major;
            if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, major);
            add_start(x0, y0, x1, y1, $urandom_range(0, 39) == 0);
            add_steps(steps);
            rand_items += 1 + steps;
            if (steps == major) add_steps($urandom_range(0, 1));
         end else if (sel < 85) begin
            add_steps($urandom_range(1, 3));
         end else if (sel < 92) begin
            x0 = coord_type'($urandom);
            y0 = coord_type'($urandom);
            add_start(x0, y0, x0, y0, 1'b0);
            rand_items++;
         end else begin
            steps = $urandom_range(0, 3);
            add_start(coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), 1'b0);
            add_steps(steps);
            rand_items += 1 + steps;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (line_reqs.size() > 0 || req_valid);
      do @(negedge clock); while (issued != rsp_count);
      repeat (8) @(negedge clock);

      if (mismatches == 0 && pixel_expect.size() == 0 && issued == rsp_count) begin
         $display("[bresenham_line_stepper] OK");
      end else begin
         $display("[bresenham_line_stepper] ERROR");
      end
      $finish;
   end

endmodule
